/* hdl/nmea_rmc_pkg.sv */
// ----------------------------------------------------------------------------
// NMEA RMC field extractor package
// Shared types, constants and digit conversion functions.
// ----------------------------------------------------------------------------
package nmea_rmc_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned HISTORY_DEPTH = 12;
  localparam int unsigned SNAP_DEPTH    = 12;
  localparam int unsigned POS_W         = 8;
  localparam int unsigned CFG_INDEX_W   = 2;
  localparam int unsigned CFG_DATA_W    = 8;

  localparam int unsigned VALUE_A_W = 10;
  localparam int unsigned VALUE_B_W = 7;
  localparam int unsigned VALUE_C_W = 12;
  localparam int unsigned VALUE_D_W = 7;
  localparam int unsigned CALC_W    = 12;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned OUT_USER_W = 2;

  localparam logic [POS_W-1:0] TIME_POS_RST = 8'd8;
  localparam logic [POS_W-1:0] LAT_POS_RST  = 8'd26;
  localparam logic [POS_W-1:0] LON_POS_RST  = 8'd39;
  localparam logic [POS_W-1:0] DATE_POS_RST = 8'd58;

  localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CHAR_G      = 8'h47;
  localparam logic [BYTE_W-1:0] CHAR_P      = 8'h50;
  localparam logic [BYTE_W-1:0] CHAR_R      = 8'h52;
  localparam logic [BYTE_W-1:0] CHAR_M      = 8'h4D;
  localparam logic [BYTE_W-1:0] CHAR_N      = 8'h4E;
  localparam logic [BYTE_W-1:0] CHAR_W      = 8'h57;

  localparam logic [CALC_W-1:0] ASCII_ZERO = 12'h030;
  localparam logic [CALC_W-1:0] YEAR_BASE  = 12'd2000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TIME_POS = 2'd0,
    CFG_LAT_POS  = 2'd1,
    CFG_LON_POS  = 2'd2,
    CFG_DATE_POS = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_TIME = 2'd0,
    KIND_LAT  = 2'd1,
    KIND_LON  = 2'd2,
    KIND_DATE = 2'd3
  } record_kind_t;

  typedef struct packed {
    record_kind_t                          kind;
    logic [SNAP_DEPTH-1:0][BYTE_W-1:0]     hist;
  } match_item_t;

  function automatic logic [CALC_W-1:0] digit_val(input logic [BYTE_W-1:0] ch);
    digit_val = {{(CALC_W-BYTE_W){1'b0}}, ch} - ASCII_ZERO;
  endfunction

  function automatic logic [CALC_W-1:0] digit_pair(input logic [BYTE_W-1:0] hi,
                                                   input logic [BYTE_W-1:0] lo);
    digit_pair = CALC_W'(digit_val(hi) * CALC_W'(10)) + digit_val(lo);
  endfunction

  function automatic logic [CALC_W-1:0] digit_triple(input logic [BYTE_W-1:0] h2,
                                                     input logic [BYTE_W-1:0] hi,
                                                     input logic [BYTE_W-1:0] lo);
    digit_triple = CALC_W'(digit_val(h2) * CALC_W'(100)) + digit_pair(hi, lo);
  endfunction

endpackage

/* hdl/nmea_rmc_match.sv */
// ----------------------------------------------------------------------------
// NMEA RMC position matcher
// Keeps the byte history, the header detector and the position counter,
// and registers a snapshot of the history when a configured position hits.
// ----------------------------------------------------------------------------
module nmea_rmc_match #(
  parameter int unsigned HISTORY_DEPTH = nmea_rmc_pkg::HISTORY_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [nmea_rmc_pkg::BYTE_W-1:0]       in_byte,
  input  logic [nmea_rmc_pkg::POS_W-1:0]        time_pos,
  input  logic [nmea_rmc_pkg::POS_W-1:0]        lat_pos,
  input  logic [nmea_rmc_pkg::POS_W-1:0]        lon_pos,
  input  logic [nmea_rmc_pkg::POS_W-1:0]        date_pos,
  output logic                                  item_valid,
  input  logic                                  item_ready,
  output nmea_rmc_pkg::match_item_t             item
);

  logic [HISTORY_DEPTH-1:0][nmea_rmc_pkg::BYTE_W-1:0] history;
  logic [HISTORY_DEPTH-1:0][nmea_rmc_pkg::BYTE_W-1:0] history_next;
  logic [nmea_rmc_pkg::POS_W-1:0]                     position_count;
  logic [nmea_rmc_pkg::POS_W-1:0]                     count_base;
  logic                                               sentence_busy;
  logic                                               busy_now;
  logic                                               header_hit;
  logic                                               hit;
  logic                                               accept;
  nmea_rmc_pkg::record_kind_t                         kind;

  assign in_ready = !item_valid || item_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    history_next[0] = in_byte;
    for (int i = 1; i < HISTORY_DEPTH; i++) begin
      history_next[i] = history[i-1];
    end
    header_hit = (history[3] == nmea_rmc_pkg::CHAR_DOLLAR) &&
                 (history[2] == nmea_rmc_pkg::CHAR_G) &&
                 (history[1] == nmea_rmc_pkg::CHAR_P) &&
                 (history[0] == nmea_rmc_pkg::CHAR_R) &&
                 (in_byte == nmea_rmc_pkg::CHAR_M);
    count_base = header_hit ? '0 : position_count;
    busy_now   = sentence_busy || header_hit;
    hit        = 1'b1;
    if (count_base == time_pos) begin
      kind = nmea_rmc_pkg::KIND_TIME;
    end else if (count_base == lat_pos) begin
      kind = nmea_rmc_pkg::KIND_LAT;
    end else if (count_base == lon_pos) begin
      kind = nmea_rmc_pkg::KIND_LON;
    end else if (count_base == date_pos) begin
      kind = nmea_rmc_pkg::KIND_DATE;
    end else begin
      kind = nmea_rmc_pkg::KIND_TIME;
      hit  = 1'b0;
    end
    hit = hit && busy_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history        <= '0;
      position_count <= '0;
      sentence_busy  <= 1'b0;
      item_valid     <= 1'b0;
    end else begin
      if (accept) begin
        history        <= history_next;
        position_count <= count_base + 1'b1;
        sentence_busy  <= busy_now && !(hit && kind == nmea_rmc_pkg::KIND_DATE);
      end
      if (in_ready) begin
        item_valid <= accept && hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_ready) begin
      item.kind <= kind;
      for (int k = 0; k < nmea_rmc_pkg::SNAP_DEPTH; k++) begin
        item.hist[k] <= history_next[k];
      end
    end
  end

endmodule

/* hdl/nmea_rmc_decode.sv */
// ----------------------------------------------------------------------------
// NMEA RMC record decoder
// Converts the ASCII digits of a matched snapshot into binary fields and
// holds the finished record in the output register.
// ----------------------------------------------------------------------------
module nmea_rmc_decode (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    item_valid,
  output logic                                    item_ready,
  input  nmea_rmc_pkg::match_item_t               item,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [nmea_rmc_pkg::OUT_DATA_W-1:0]     out_data,
  output logic [nmea_rmc_pkg::OUT_USER_W-1:0]     out_user
);

  logic [nmea_rmc_pkg::CALC_W-1:0]    a_calc;
  logic [nmea_rmc_pkg::CALC_W-1:0]    b_calc;
  logic [nmea_rmc_pkg::CALC_W-1:0]    c_calc;
  logic [nmea_rmc_pkg::CALC_W-1:0]    d_calc;
  logic                               hemi;
  logic [nmea_rmc_pkg::OUT_DATA_W-1:0] data_next;

  assign item_ready = !out_valid || out_ready;

  always_comb begin
    a_calc = nmea_rmc_pkg::digit_pair(item.hist[5], item.hist[4]);
    b_calc = nmea_rmc_pkg::digit_pair(item.hist[3], item.hist[2]);
    c_calc = nmea_rmc_pkg::digit_pair(item.hist[1], item.hist[0]);
    d_calc = '0;
    hemi   = 1'b0;
    case (item.kind)
      nmea_rmc_pkg::KIND_TIME: begin
      end
      nmea_rmc_pkg::KIND_LAT: begin
        a_calc = nmea_rmc_pkg::digit_pair(item.hist[10], item.hist[9]);
        b_calc = nmea_rmc_pkg::digit_pair(item.hist[8], item.hist[7]);
        c_calc = nmea_rmc_pkg::digit_pair(item.hist[5], item.hist[4]);
        d_calc = nmea_rmc_pkg::digit_pair(item.hist[3], item.hist[2]);
        hemi   = (item.hist[0] == nmea_rmc_pkg::CHAR_N);
      end
      nmea_rmc_pkg::KIND_LON: begin
        a_calc = nmea_rmc_pkg::digit_triple(item.hist[11], item.hist[10], item.hist[9]);
        b_calc = nmea_rmc_pkg::digit_pair(item.hist[8], item.hist[7]);
        c_calc = nmea_rmc_pkg::digit_pair(item.hist[5], item.hist[4]);
        d_calc = nmea_rmc_pkg::digit_pair(item.hist[3], item.hist[2]);
        hemi   = (item.hist[0] == nmea_rmc_pkg::CHAR_W);
      end
      nmea_rmc_pkg::KIND_DATE: begin
        c_calc = nmea_rmc_pkg::digit_pair(item.hist[1], item.hist[0]) +
                 nmea_rmc_pkg::YEAR_BASE;
      end
      default: begin
      end
    endcase
    data_next = {3'b000, hemi,
                 d_calc[nmea_rmc_pkg::VALUE_D_W-1:0],
                 c_calc[nmea_rmc_pkg::VALUE_C_W-1:0],
                 b_calc[nmea_rmc_pkg::VALUE_B_W-1:0],
                 a_calc[nmea_rmc_pkg::VALUE_A_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_ready) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      out_data <= data_next;
      out_user <= item.kind;
    end
  end

endmodule

/* hdl/nmea_rmc_field_extractor.sv */
// ----------------------------------------------------------------------------
// NMEA RMC field extractor
// Scans a received character stream for RMC sentences and emits time,
// latitude, longitude and date records at configured byte positions.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata[7:0] rx_byte
//   m_axis    out        tdata: value_a, value_b, value_c, value_d,
//                        hemisphere_match; tuser: record_kind
//   cfg       in         cfg_we, cfg_index, cfg_data (four 8-bit positions)
//
// One byte is accepted every cycle while the input is not stalled. A record
// passes through the match register and then the output register. Reset
// clears the history, counter and busy flag and restores the default
// positions. A stall on the output holds both stages; input stalls only
// once both are full.
// ----------------------------------------------------------------------------
module nmea_rmc_field_extractor #(
  parameter int unsigned HISTORY_DEPTH = nmea_rmc_pkg::HISTORY_DEPTH
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  input  logic [nmea_rmc_pkg::BYTE_W-1:0]             s_axis_tdata,  // [7:0] rx_byte
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  // [9:0] value_a, [16:10] value_b, [28:17] value_c, [35:29] value_d,
  // [36] hemisphere_match, [39:37] zero
  output logic [nmea_rmc_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  output logic [nmea_rmc_pkg::OUT_USER_W-1:0]         m_axis_tuser,  // [1:0] record_kind
  input  logic                                        cfg_we,
  input  logic [nmea_rmc_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [nmea_rmc_pkg::CFG_DATA_W-1:0]         cfg_data
);

  logic [nmea_rmc_pkg::POS_W-1:0] time_pos;
  logic [nmea_rmc_pkg::POS_W-1:0] lat_pos;
  logic [nmea_rmc_pkg::POS_W-1:0] lon_pos;
  logic [nmea_rmc_pkg::POS_W-1:0] date_pos;
  logic                           match_valid;
  logic                           match_ready;
  nmea_rmc_pkg::match_item_t      match_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_pos <= nmea_rmc_pkg::TIME_POS_RST;
      lat_pos  <= nmea_rmc_pkg::LAT_POS_RST;
      lon_pos  <= nmea_rmc_pkg::LON_POS_RST;
      date_pos <= nmea_rmc_pkg::DATE_POS_RST;
    end else if (cfg_we) begin
      case (nmea_rmc_pkg::cfg_index_t'(cfg_index))
        nmea_rmc_pkg::CFG_TIME_POS: time_pos <= cfg_data;
        nmea_rmc_pkg::CFG_LAT_POS:  lat_pos  <= cfg_data;
        nmea_rmc_pkg::CFG_LON_POS:  lon_pos  <= cfg_data;
        nmea_rmc_pkg::CFG_DATE_POS: date_pos <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  nmea_rmc_match #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_match (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .time_pos  (time_pos),
    .lat_pos   (lat_pos),
    .lon_pos   (lon_pos),
    .date_pos  (date_pos),
    .item_valid(match_valid),
    .item_ready(match_ready),
    .item      (match_item)
  );

  nmea_rmc_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .item_valid(match_valid),
    .item_ready(match_ready),
    .item      (match_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser)
  );

endmodule

/* tb/sv/nmea_rmc_field_extractor_tb.sv */
// ----------------------------------------------------------------------------
// NMEA RMC field extractor testbench
// Streams received characters into the extractor and checks every record it
// emits against a cycle-free model of the sentence scanner. A short scripted
// sequence covers the reset positions, position zero and typed-in records.
// Random sentences with noise, truncation and corrupted characters follow,
// over several position settings, with random idling on both streams.
// ----------------------------------------------------------------------------
module nmea_rmc_field_extractor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LATENCY = 2;
  localparam int MAX_WAIT     = 11;
  localparam int STALL_LIMIT  = 1000;
  localparam int NUM_PHASES   = 5;

  typedef struct packed {
    nmea_rmc_pkg::record_kind_t                   kind;
    logic [nmea_rmc_pkg::VALUE_A_W-1:0]           a;
    logic [nmea_rmc_pkg::VALUE_B_W-1:0]           b;
    logic [nmea_rmc_pkg::VALUE_C_W-1:0]           c;
    logic [nmea_rmc_pkg::VALUE_D_W-1:0]           d;
    logic                                         hemi;
  } nav_record_t;

  typedef enum logic {ROW_RX, ROW_SETUP} row_op_t;

  typedef struct packed {
    row_op_t                                      op;
    logic [nmea_rmc_pkg::BYTE_W-1:0]              rx;
    logic                                         check;
    nav_record_t                                  rec;
    logic [3:0][nmea_rmc_pkg::POS_W-1:0]          pos;
  } stim_row_t;

  typedef struct packed {
    logic [3:0][nmea_rmc_pkg::POS_W-1:0]          pos;
    int                                           sentences;
    int                                           extra;
  } phase_t;

  logic                                      clk = 1'b0;
  logic                                      rst = 1'b1;
  logic                                      s_axis_tvalid = 1'b0;
  logic                                      s_axis_tready;
  logic [nmea_rmc_pkg::BYTE_W-1:0]           s_axis_tdata = '0;
  logic                                      m_axis_tvalid;
  logic                                      m_axis_tready = 1'b0;
  logic [nmea_rmc_pkg::OUT_DATA_W-1:0]       m_axis_tdata;
  logic [nmea_rmc_pkg::OUT_USER_W-1:0]       m_axis_tuser;
  logic                                      cfg_we = 1'b0;
  logic [nmea_rmc_pkg::CFG_INDEX_W-1:0]      cfg_index = '0;
  logic [nmea_rmc_pkg::CFG_DATA_W-1:0]       cfg_data = '0;

  logic [nmea_rmc_pkg::BYTE_W-1:0]  rx_history [nmea_rmc_pkg::HISTORY_DEPTH] =
                                      '{default: '0};
  logic [nmea_rmc_pkg::POS_W-1:0]   sent_count = '0;
  logic                             in_sentence = 1'b0;
  logic [3:0][nmea_rmc_pkg::POS_W-1:0] field_pos = {nmea_rmc_pkg::DATE_POS_RST,
                                                    nmea_rmc_pkg::LON_POS_RST,
                                                    nmea_rmc_pkg::LAT_POS_RST,
                                                    nmea_rmc_pkg::TIME_POS_RST};

  nav_record_t             pending_records [$];
  stim_row_t               script [$];
  phase_t                  phases [NUM_PHASES];
  int                      mismatch_count = 0;
  int                      rx_count = 0;
  int                      idle_cycles = 0;
  int                      stall_left = 0;
  int                      settings_count = 1;
  int                      kind_seen [4] = '{default: 0};
  bit                      rx_gaps = 1'b0;
  bit                      sink_stalls = 1'b0;

  nmea_rmc_field_extractor DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [3:0][nmea_rmc_pkg::POS_W-1:0] positions(
      input int t, input int la, input int lo, input int dt);
    return {nmea_rmc_pkg::POS_W'(dt), nmea_rmc_pkg::POS_W'(lo),
            nmea_rmc_pkg::POS_W'(la), nmea_rmc_pkg::POS_W'(t)};
  endfunction

  function automatic logic [31:0] ascii_digit(input int k);
    return {24'd0, rx_history[k]} - 32'(nmea_rmc_pkg::ASCII_ZERO);
  endfunction

  function automatic logic [31:0] ascii_pair(input int hi, input int lo);
    return 32'd10 * ascii_digit(hi) + ascii_digit(lo);
  endfunction

  function automatic bit predict_record(input logic [nmea_rmc_pkg::BYTE_W-1:0] rx,
                                        output nav_record_t rec);
    logic [31:0]                a;
    logic [31:0]                b;
    logic [31:0]                c;
    logic [31:0]                d;
    logic                       hemi;
    bit                         found;
    nmea_rmc_pkg::record_kind_t kind;
    int                         i;
    a = '0;
    b = '0;
    c = '0;
    d = '0;
    hemi = 1'b0;
    found = 1'b0;
    kind = nmea_rmc_pkg::KIND_TIME;
    for (i = nmea_rmc_pkg::HISTORY_DEPTH - 1; i > 0; i--) rx_history[i] = rx_history[i-1];
    rx_history[0] = rx;
    if (rx_history[4] == nmea_rmc_pkg::CHAR_DOLLAR && rx_history[3] == nmea_rmc_pkg::CHAR_G &&
        rx_history[2] == nmea_rmc_pkg::CHAR_P && rx_history[1] == nmea_rmc_pkg::CHAR_R &&
        rx_history[0] == nmea_rmc_pkg::CHAR_M) begin
      sent_count = '0;
      in_sentence = 1'b1;
    end
    if (in_sentence) begin
      // Scanning downward leaves the lowest-numbered matching kind in kind.
      for (i = 3; i >= 0; i--) begin
        if (sent_count == field_pos[i]) begin
          found = 1'b1;
          kind = nmea_rmc_pkg::record_kind_t'(i);
        end
      end
      if (found) begin
        case (kind)
          nmea_rmc_pkg::KIND_TIME: begin
            a = ascii_pair(5, 4);
            b = ascii_pair(3, 2);
            c = ascii_pair(1, 0);
          end
          nmea_rmc_pkg::KIND_LAT: begin
            a = ascii_pair(10, 9);
            b = ascii_pair(8, 7);
            c = ascii_pair(5, 4);
            d = ascii_pair(3, 2);
            hemi = (rx_history[0] == nmea_rmc_pkg::CHAR_N);
          end
          nmea_rmc_pkg::KIND_LON: begin
            a = 32'd100 * ascii_digit(11) + ascii_pair(10, 9);
            b = ascii_pair(8, 7);
            c = ascii_pair(5, 4);
            d = ascii_pair(3, 2);
            hemi = (rx_history[0] == nmea_rmc_pkg::CHAR_W);
          end
          nmea_rmc_pkg::KIND_DATE: begin
            a = ascii_pair(5, 4);
            b = ascii_pair(3, 2);
            c = ascii_pair(1, 0) + 32'(nmea_rmc_pkg::YEAR_BASE);
            in_sentence = 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
    rec = '{kind, a[nmea_rmc_pkg::VALUE_A_W-1:0], b[nmea_rmc_pkg::VALUE_B_W-1:0],
            c[nmea_rmc_pkg::VALUE_C_W-1:0], d[nmea_rmc_pkg::VALUE_D_W-1:0], hemi};
    sent_count = sent_count + 1'b1;
    return found;
  endfunction

  function automatic void add_text(input string s);
    int k;
    for (k = 0; k < s.len(); k++) script.push_back('{ROW_RX, s[k], 1'b0, '0, '0});
  endfunction

  function automatic logic [nmea_rmc_pkg::BYTE_W-1:0] rand_filler();
    case ($urandom_range(0, 9))
      0:       return ",";
      1:       return ".";
      2:       return nmea_rmc_pkg::BYTE_W'($urandom_range(0, 255));
      default: return "0" + nmea_rmc_pkg::BYTE_W'($urandom_range(0, 9));
    endcase
  endfunction

  task automatic log_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH at %0d ns: %s", $time, msg);
  endtask

  task automatic check_record();
    nav_record_t got;
    nav_record_t want;
    got = '{nmea_rmc_pkg::record_kind_t'(m_axis_tuser), m_axis_tdata[9:0],
            m_axis_tdata[16:10], m_axis_tdata[28:17], m_axis_tdata[35:29],
            m_axis_tdata[36]};
    if (pending_records.size() == 0) begin
      log_mismatch($sformatf("record of kind %0d with none expected", m_axis_tuser));
    end else begin
      want = pending_records.pop_front();
      kind_seen[want.kind]++;
      if (got !== want)
        log_mismatch($sformatf({"got kind %0d a %0d b %0d c %0d d %0d hemi %0b, ",
                                "expected kind %0d a %0d b %0d c %0d d %0d hemi %0b"},
                               got.kind, got.a, got.b, got.c, got.d, got.hemi,
                               want.kind, want.a, want.b, want.c, want.d, want.hemi));
    end
  endtask

  always @(posedge clk) begin
    if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
      check_record();
      stall_left = sink_stalls ? $urandom_range(0, MAX_WAIT) : 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles, %0d records outstanding",
               idle_cycles, pending_records.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_rx(input logic [nmea_rmc_pkg::BYTE_W-1:0] rx, output bit made,
                         output nav_record_t rec);
    int gap;
    gap = rx_gaps ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= rx;
    do @(posedge clk); while (!s_axis_tready);
    made = predict_record(rx, rec);
    rx_count++;
  endtask

  task automatic feed_byte(input logic [nmea_rmc_pkg::BYTE_W-1:0] rx);
    bit          made;
    nav_record_t rec;
    send_rx(rx, made, rec);
    if (made) pending_records.push_back(rec);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_records.size() > 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic set_positions(input logic [3:0][nmea_rmc_pkg::POS_W-1:0] pos);
    int i;
    for (i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= nmea_rmc_pkg::cfg_index_t'(i);
      cfg_data <= pos[i];
      field_pos[i] = pos[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  task automatic send_sentence(input logic [3:0][nmea_rmc_pkg::POS_W-1:0] pos,
                               input int extra);
    logic [nmea_rmc_pkg::BYTE_W-1:0] body [$];
    string                           fld;
    string                           header;
    int                              top;
    int                              len;
    int                              cut;
    int                              k;
    int                              kk;
    int                              idx;
    header = "$GPRM";
    rx_gaps = 1'($urandom_range(0, 1));
    sink_stalls = 1'($urandom_range(0, 1));
    top = 0;
    for (k = 0; k < 4; k++) if (int'(pos[k]) > top) top = int'(pos[k]);
    len = top + extra;
    repeat ($urandom_range(0, 3)) feed_byte(nmea_rmc_pkg::BYTE_W'($urandom_range(0, 255)));
    if ($urandom_range(0, 7) == 0)
      for (k = 0; k < 4; k++) feed_byte(header[k]);
    for (k = 0; k < len; k++) body.push_back(rand_filler());
    for (kk = 3; kk >= 0; kk--) begin
      case (nmea_rmc_pkg::record_kind_t'(kk))
        nmea_rmc_pkg::KIND_TIME: fld = $sformatf("%06d", $urandom_range(0, 999999));
        nmea_rmc_pkg::KIND_LAT:  fld = $sformatf("%04d.%04d,%s", $urandom_range(0, 9999),
                                                 $urandom_range(0, 9999),
                                                 $urandom_range(0, 1) ? "N" : "S");
        nmea_rmc_pkg::KIND_LON:  fld = $sformatf("%05d.%04d,%s", $urandom_range(0, 99999),
                                                 $urandom_range(0, 9999),
                                                 $urandom_range(0, 1) ? "W" : "E");
        nmea_rmc_pkg::KIND_DATE: fld = $sformatf("%06d", $urandom_range(0, 999999));
        default:                 fld = "";
      endcase
      for (k = 0; k < fld.len(); k++) begin
        idx = int'(pos[kk]) - fld.len() + k;
        if (idx >= 0 && idx < len)
          body[idx] = ($urandom_range(0, 15) == 0) ?
                      nmea_rmc_pkg::BYTE_W'($urandom_range(0, 255)) : fld[k];
      end
    end
    cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len - 1) : len;
    for (k = 0; k < header.len(); k++) feed_byte(header[k]);
    for (k = 0; k < cut; k++) feed_byte(body[k]);
  endtask

  initial begin
    bit          made;
    nav_record_t rec;
    int          p;
    phases[0] = '{positions(8, 26, 39, 58), 4, 4};
    phases[1] = '{positions(6, 17, 29, 36), 4, 4};
    phases[2] = '{positions(1, 12, 24, 255), 1, 3};
    phases[3] = '{positions(0, 0, 200, 200), 1, 70};
    phases[4] = '{positions(11, 11, 12, 13), 8, 3};

    add_text("$GPRMC,12345");
    script.push_back('{ROW_RX, "6", 1'b1,
                       '{nmea_rmc_pkg::KIND_TIME, 10'd12, 7'd34, 12'd56, 7'd0, 1'b0}, '0});
    script.push_back('{ROW_SETUP, '0, 1'b0, '0, positions(6, 0, 0, 12)});
    add_text("$GPRM12345");
    script.push_back('{ROW_RX, "6", 1'b1,
                       '{nmea_rmc_pkg::KIND_TIME, 10'd12, 7'd34, 12'd56, 7'd0, 1'b0}, '0});
    add_text("31129");
    script.push_back('{ROW_RX, "9", 1'b1,
                       '{nmea_rmc_pkg::KIND_DATE, 10'd31, 7'd12, 12'd2099, 7'd0, 1'b0}, '0});
    script.push_back('{ROW_RX, 8'h00, 1'b0, '0, '0});
    script.push_back('{ROW_RX, 8'hFF, 1'b0, '0, '0});

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].op == ROW_SETUP) begin
        settle();
        set_positions(script[i].pos);
      end else begin
        rx_gaps = 1'($urandom_range(0, 1));
        sink_stalls = 1'($urandom_range(0, 1));
        send_rx(script[i].rx, made, rec);
        if (script[i].check)
          pending_records.push_back(script[i].rec);
        else if (made)
          pending_records.push_back(rec);
      end
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      settle();
      set_positions(phases[p].pos);
      repeat (phases[p].sentences) send_sentence(phases[p].pos, phases[p].extra);
    end
    settle();

    $display("Sent %0d characters; checked %0d time, %0d latitude, %0d longitude, %0d date",
             rx_count, kind_seen[nmea_rmc_pkg::KIND_TIME], kind_seen[nmea_rmc_pkg::KIND_LAT],
             kind_seen[nmea_rmc_pkg::KIND_LON], kind_seen[nmea_rmc_pkg::KIND_DATE]);
    $display("Covered %0d position settings incl. position zero, shared positions and count wrap",
             settings_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
